// ===== src/card_frame_deframer_xor_top_assert.svh =====
// Assertion macros shared by the deframer checker.
// Each macro expects signals named clk and rst_n in the scope that uses it.
`ifndef CARD_FRAME_DEFRAMER_XOR_TOP_ASSERT_SVH
`define CARD_FRAME_DEFRAMER_XOR_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CFDX_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CFDX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/cfdx_pkg.sv =====
// Types and constants for the card frame deframer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package cfdx_pkg;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_HDR_ERR = 2'd1,
        STAT_XOR_ERR = 2'd2
    } status_t;

    localparam int          REG_IDX_W  = 2;
    localparam logic [1:0]  REG_START  = 2'd0;
    localparam logic [1:0]  REG_LENGTH = 2'd1;
    localparam logic [1:0]  REG_STATUS = 2'd2;

    localparam logic [7:0]  START_RST  = 8'hAA;
    localparam logic [7:0]  LENGTH_RST = 8'h11;
    localparam logic [7:0]  STATUS_RST = 8'h00;

    typedef struct packed {
        logic [7:0] start_code;
        logic [7:0] length_code;
        logic [7:0] status_code;
    } cfg_t;

    // frame_status sits in the lowest bits, as on the output bus.
    typedef struct packed {
        logic [15:0] basket_id;
        logic [7:0]  window_id;
        status_t     frame_status;
    } res_t;

    localparam int TDATA_W = 32;
    localparam int PAD_W   = TDATA_W - $bits(res_t);

endpackage

// ===== src/card_frame_deframer_xor_top.sv =====
// A result word is registered in cfdx_out_buf, or in its skid stage during a stall.
// One byte is taken per cycle while s_axis_tready is high; a header result follows
// three bytes, a frame result DATA_BYTES + 5 bytes. s_axis_tready drops only while the
// skid stage holds a result. Reset (rst_n, async, active low) restores the default header
// codes and the parser to waiting for a start byte, and empties the output stages.
`timescale 1ns / 1ps

module card_frame_deframer_xor_top #(
    parameter int DATA_BYTES = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [cfdx_pkg::REG_IDX_W-1:0]  cfg_addr,
    input  logic [7:0]                      cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [7:0] rx_byte
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [1:0] frame_status, [9:2] window_id, [25:10] basket_id, [31:26] zero
    output logic [cfdx_pkg::TDATA_W-1:0]    m_axis_tdata
);

    cfdx_pkg::cfg_t cfg;
    cfdx_pkg::res_t res;
    cfdx_pkg::res_t out_res;
    logic           res_valid;
    logic           byte_accept;

    assign byte_accept = s_axis_tvalid && s_axis_tready;

    cfdx_cfg u_cfg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (cfg_wr_en),
        .addr  (cfg_addr),
        .wdata (cfg_wdata),
        .cfg   (cfg)
    );

    cfdx_parser #(
        .DATA_BYTES (DATA_BYTES)
    ) u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_accept),
        .rx_byte    (s_axis_tdata),
        .cfg        (cfg),
        .res_valid  (res_valid),
        .res        (res)
    );

    cfdx_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_res    (res),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_res   (out_res),
        .out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {{cfdx_pkg::PAD_W{1'b0}}, out_res};

endmodule

// ===== src/cfdx_cfg.sv =====
// Header code registers of the deframer, written through a plain write port.
// Depends on cfdx_pkg.
`timescale 1ns / 1ps

module cfdx_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [cfdx_pkg::REG_IDX_W-1:0] addr,
    input  logic [7:0]                     wdata,
    output cfdx_pkg::cfg_t                 cfg
);

    cfdx_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_code  <= cfdx_pkg::START_RST;
            cfg_reg.length_code <= cfdx_pkg::LENGTH_RST;
            cfg_reg.status_code <= cfdx_pkg::STATUS_RST;
        end
        else if (wr_en)
        begin
            case (addr)
                cfdx_pkg::REG_START:  cfg_reg.start_code  <= wdata;
                cfdx_pkg::REG_LENGTH: cfg_reg.length_code <= wdata;
                cfdx_pkg::REG_STATUS: cfg_reg.status_code <= wdata;
                default:              ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/cfdx_parser.sv =====
// Frame parser: byte position counter, running XOR and payload holds.
// Produces at most one result per accepted byte. Depends on cfdx_pkg.
`timescale 1ns / 1ps

module cfdx_parser #(
    parameter int DATA_BYTES = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             byte_valid,
    input  logic [7:0]       rx_byte,
    input  cfdx_pkg::cfg_t   cfg,
    output logic             res_valid,
    output cfdx_pkg::res_t   res
);

    localparam int POS_W = $clog2(DATA_BYTES + 5);
    localparam logic [POS_W-1:0] POS_XOR = POS_W'(DATA_BYTES + 3);
    localparam logic [POS_W-1:0] POS_END = POS_W'(DATA_BYTES + 4);
    localparam logic [POS_W-1:0] POS_H1  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_H2  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_P0  = POS_W'(3);
    localparam logic [POS_W-1:0] POS_P1  = POS_W'(4);
    localparam logic [POS_W-1:0] POS_P2  = POS_W'(5);

    logic [POS_W-1:0] pos_reg,      pos_next;
    logic [7:0]       xor_reg,      xor_next;
    logic             hdr_good_reg, hdr_good_next;
    logic             xor_good_reg, xor_good_next;
    logic [7:0]       window_reg,   window_next;
    logic [7:0]       bhigh_reg,    bhigh_next;
    logic [7:0]       blow_reg,     blow_next;

    logic [7:0]       expect_byte;
    logic             hdr_ok;

    always_comb
    begin
        if (pos_reg == '0)
            expect_byte = cfg.start_code;
        else if (pos_reg == POS_H1)
            expect_byte = cfg.length_code;
        else
            expect_byte = cfg.status_code;
    end

    assign hdr_ok = hdr_good_reg && (rx_byte == expect_byte);

    always_comb
    begin
        pos_next      = pos_reg;
        xor_next      = xor_reg;
        hdr_good_next = hdr_good_reg;
        xor_good_next = xor_good_reg;
        window_next   = window_reg;
        bhigh_next    = bhigh_reg;
        blow_next     = blow_reg;
        res_valid     = 1'b0;
        res.frame_status = cfdx_pkg::STAT_OK;
        res.window_id    = 8'd0;
        res.basket_id    = 16'd0;

        if (byte_valid)
        begin
            if (pos_reg < POS_P0)
            begin
                if (pos_reg == POS_H2 && !hdr_ok)
                begin
                    // Bad header: report and drop back to waiting for a start byte.
                    res_valid        = 1'b1;
                    res.frame_status = cfdx_pkg::STAT_HDR_ERR;
                    pos_next         = '0;
                    xor_next         = 8'd0;
                    hdr_good_next    = 1'b1;
                    xor_good_next    = 1'b0;
                end
                else
                begin
                    pos_next      = pos_reg + POS_W'(1);
                    xor_next      = xor_reg ^ rx_byte;
                    hdr_good_next = hdr_ok;
                end
            end
            else if (pos_reg < POS_XOR)
            begin
                if (pos_reg == POS_P0)
                    window_next = rx_byte;
                if (pos_reg == POS_P1)
                    bhigh_next = rx_byte;
                if (pos_reg == POS_P2)
                    blow_next = rx_byte;
                xor_next = xor_reg ^ rx_byte;
                pos_next = pos_reg + POS_W'(1);
            end
            else if (pos_reg == POS_XOR)
            begin
                xor_good_next = (xor_reg == rx_byte);
                pos_next      = POS_END;
            end
            else
            begin
                // End byte: its value is not checked.
                res_valid = 1'b1;
                if (xor_good_reg)
                begin
                    res.frame_status = cfdx_pkg::STAT_OK;
                    res.window_id    = window_reg;
                    res.basket_id    = {bhigh_reg, blow_reg};
                end
                else
                begin
                    res.frame_status = cfdx_pkg::STAT_XOR_ERR;
                end
                pos_next      = '0;
                xor_next      = 8'd0;
                hdr_good_next = 1'b1;
                xor_good_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            xor_reg      <= 8'd0;
            hdr_good_reg <= 1'b1;
            xor_good_reg <= 1'b0;
            window_reg   <= 8'd0;
            bhigh_reg    <= 8'd0;
            blow_reg     <= 8'd0;
        end
        else
        begin
            pos_reg      <= pos_next;
            xor_reg      <= xor_next;
            hdr_good_reg <= hdr_good_next;
            xor_good_reg <= xor_good_next;
            window_reg   <= window_next;
            bhigh_reg    <= bhigh_next;
            blow_reg     <= blow_next;
        end
    end

endmodule

// ===== src/cfdx_out_buf.sv =====
// Result register with a skid stage toward the output bus.
// Input is refused only while the skid stage is occupied. Depends on cfdx_pkg.
`timescale 1ns / 1ps

module cfdx_out_buf
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  cfdx_pkg::res_t   in_res,
    output logic             in_ready,
    output logic             out_valid,
    output cfdx_pkg::res_t   out_res,
    input  logic             out_ready
);

    logic             out_valid_reg;
    logic             skid_valid_reg;
    cfdx_pkg::res_t   out_res_reg;
    cfdx_pkg::res_t   skid_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_valid;
            end
        end
        else if (in_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
                out_res_reg <= skid_res_reg;
            else if (in_valid)
                out_res_reg <= in_res;
        end
        else if (in_valid)
        begin
            skid_res_reg <= in_res;
        end
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

// ===== src/cfdx_checker.sv =====
// Port-level checks on the deframer's result bus, bound to the top level.
// Depends on cfdx_pkg and card_frame_deframer_xor_top_assert.svh.
`timescale 1ns / 1ps
`include "card_frame_deframer_xor_top_assert.svh"

module cfdx_checker
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic [cfdx_pkg::TDATA_W-1:0] m_axis_tdata
);

    logic [1:0] stat;
    logic       not_ok;

    assign stat   = m_axis_tdata[1:0];
    assign not_ok = (stat != cfdx_pkg::STAT_OK);

    // A stalled result word must stay put until taken.
    `CFDX_ASSERT_NEXT(a_hold_on_stall, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")
    `CFDX_ASSERT_NOW(a_status_legal, m_axis_tvalid, stat != 2'd3, "undefined frame status")
    // Error results carry no ids.
    `CFDX_ASSERT_NOW(a_err_ids_zero, m_axis_tvalid && not_ok, m_axis_tdata[25:2] == 24'd0, "ids nonzero on an error result")
    `CFDX_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[31:26] == 6'd0, "pad bits nonzero")

endmodule

bind card_frame_deframer_xor_top cfdx_checker u_cfdx_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
